// ===== rtl/bss_pkg.sv =====
// shared types and constants of the bounded substring search
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

  localparam int unsigned QUERY_W  = 64;  // query register width
  localparam int unsigned LEN_W    = 4;   // query length register width
  localparam int unsigned LIMIT_W  = 16;  // search limit register width
  localparam int unsigned INDEX_W  = 16;  // match index width
  localparam int unsigned BYTE_SEL = 3;   // selects one of the eight query bytes
  localparam int unsigned ADDR_W   = 5;   // registers sit at 8-byte steps

  typedef enum logic [1:0] {
    REG_QUERY_BYTES  = 2'd0,
    REG_QUERY_LENGTH = 2'd1,
    REG_SEARCH_LIMIT = 2'd2
  } reg_idx_e;

  // what a window cell hands on and reports
  typedef struct packed {
    logic [7:0] data;  // byte held in this cell
    logic       hit;   // cell agrees with its query byte, or is outside the query
  } bss_cell_out_t;

endpackage

`default_nettype wire

// ===== rtl/bss_cell.sv =====
// one window cell: holds a byte, passes it on, compares the incoming byte
`timescale 1ns / 1ps
`default_nettype none

module bss_cell
  import bss_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               shift_i,
  input  wire logic               clear_i,
  input  wire logic [7:0]         data_i,
  input  wire logic [QUERY_W-1:0] query_bytes_i,
  input  wire logic [LEN_W-1:0]   len_i,
  output bss_cell_out_t           out_o
);

  logic [7:0]       data_q, data_d;
  logic [LEN_W-1:0] sel;
  logic [7:0]       qbyte;
  logic             in_query;

  // byte that enters this cell on a shift
  assign data_d   = clear_i ? 8'd0 : data_i;

  // newest byte pairs with the last query byte
  assign in_query = LEN_W'(IDX) < len_i;
  assign sel      = len_i - LEN_W'(1) - LEN_W'(IDX);
  assign qbyte    = query_bytes_i[{sel[BYTE_SEL-1:0], 3'b000} +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= 8'd0;
    end else if (shift_i) begin
      data_q <= data_d;
    end
  end

  assign out_o.data = data_q;
  assign out_o.hit  = !in_query || (data_d == qbyte);

endmodule

`default_nettype wire

// ===== rtl/bounded_substring_search.sv =====
// top level of the bounded substring search with its register port
`timescale 1ns / 1ps
`default_nettype none

// Searches a byte stream for a configured query of up to QUERY_MAX bytes and reports the
// first match that ends within the first search_limit bytes of a string. One byte is taken
// per transfer and a new byte can be taken every cycle unless an unread result stalls input:
// the window is a row of QUERY_MAX cells that shift on each byte and compare in parallel,
// and a byte's result, if any, is registered for the next cycle. string_start marks the
// first byte of a string and drops any search in progress. Each string gives one result:
// found with the start index, or not found on a zero byte, on the last window that fits the
// limit, on a query longer than the limit, or when the position counter runs out. An empty
// query is found at index 0 on a nonzero first byte. Bytes after a result are dropped until
// the next start. Registers sit at byte addresses 0 (query bytes, first byte lowest), 8
// (query length, above QUERY_MAX acts as QUERY_MAX) and 16 (search limit); write them only
// while no string is in flight.
module bounded_substring_search
  import bss_pkg::*;
#(
  parameter int unsigned QUERY_MAX     = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // byte stream
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         char_byte_i,
  input  wire logic               string_start_i,
  // results
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    found_o,
  output logic [INDEX_W-1:0]      match_index_o,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [QUERY_W-1:0] pwdata,
  output logic [QUERY_W-1:0]      prdata,
  output logic                    pready
);

  // wide enough for position plus one and for the limit
  localparam int unsigned CMP_W = (POSITION_BITS + 1 > LIMIT_W + 1) ?
                                  POSITION_BITS + 1 : LIMIT_W + 1;

  // ---------------- registers ----------------
  logic [QUERY_W-1:0] query_bytes_q;
  logic [LEN_W-1:0]   query_length_q;
  logic [LIMIT_W-1:0] search_limit_q;
  reg_idx_e           reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_bytes_q  <= '0;
      query_length_q <= '0;
      search_limit_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_QUERY_BYTES:  query_bytes_q  <= pwdata;
        REG_QUERY_LENGTH: query_length_q <= pwdata[LEN_W-1:0];
        REG_SEARCH_LIMIT: search_limit_q <= pwdata[LIMIT_W-1:0];
        default: ;  // addresses past the list are ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUERY_BYTES:  prdata = query_bytes_q;
      REG_QUERY_LENGTH: prdata = QUERY_W'(query_length_q);
      REG_SEARCH_LIMIT: prdata = QUERY_W'(search_limit_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------- search state ----------------
  logic [POSITION_BITS-1:0] pos_q;
  logic                     done_q;
  logic                     out_valid_q;
  logic                     found_q;
  logic [INDEX_W-1:0]       index_q;

  logic                     in_fire;
  logic                     active;
  logic [POSITION_BITS-1:0] pos_cur;
  logic [LEN_W-1:0]         len_eff;
  logic [CMP_W-1:0]         pos_inc;
  logic [CMP_W-1:0]         len_ext;
  logic [CMP_W-1:0]         limit_ext;
  logic [CMP_W-1:0]         start_idx;
  logic                     early_miss;
  logic                     empty_hit;
  logic                     shift;
  logic                     window_hit;
  logic                     end_miss;
  logic                     result;
  logic                     res_found;
  logic [INDEX_W-1:0]       res_index;
  logic [QUERY_MAX-1:0]     hit_vec;

  // output register parts the two sides; a waiting result blocks input only until it is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // a start reopens the search from position zero
  assign active  = string_start_i || !done_q;
  assign pos_cur = string_start_i ? '0 : pos_q;

  assign len_eff   = (query_length_q > LEN_W'(QUERY_MAX)) ? LEN_W'(QUERY_MAX)
                                                          : query_length_q;
  assign pos_inc   = CMP_W'(pos_cur) + CMP_W'(1);
  assign len_ext   = CMP_W'(len_eff);
  assign limit_ext = CMP_W'(search_limit_q);
  assign start_idx = pos_inc - len_ext;

  // terminator or a query that cannot fit the limit
  assign early_miss = (char_byte_i == 8'd0) || (len_ext > limit_ext);
  assign empty_hit  = !early_miss && (len_eff == '0);
  assign shift      = in_fire && active && !early_miss && !empty_hit;

  // ---------------- window cells ----------------
  for (genvar j = 0; j < QUERY_MAX; j++) begin : g_cell
    bss_cell_out_t cell_out;
    logic [7:0]    link;
    logic          clr;

    if (j == 0) begin : g_head
      assign link = char_byte_i;
      assign clr  = 1'b0;
    end else begin : g_tail
      assign link = g_cell[j-1].cell_out.data;
      assign clr  = string_start_i;  // older slots empty on a new string
    end

    bss_cell #(
      .IDX (j)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .shift_i       (shift),
      .clear_i       (clr),
      .data_i        (link),
      .query_bytes_i (query_bytes_q),
      .len_i         (len_eff),
      .out_o         (cell_out)
    );

    assign hit_vec[j] = cell_out.hit;
  end

  // window holds a full query only once enough bytes have arrived
  assign window_hit = (pos_inc >= len_ext) && (&hit_vec);
  assign end_miss   = (pos_inc >= limit_ext) || (&pos_cur);

  always_comb begin
    result    = 1'b0;
    res_found = 1'b0;
    res_index = '0;
    if (active) begin
      if (early_miss) begin
        result = 1'b1;
      end else if (empty_hit) begin
        result    = 1'b1;
        res_found = 1'b1;
      end else if (window_hit) begin
        result    = 1'b1;
        res_found = 1'b1;
        res_index = start_idx[INDEX_W-1:0];
      end else if (end_miss) begin
        result = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b1;  // wait for a string start
      pos_q  <= '0;
    end else if (in_fire && active) begin
      done_q <= result;
      if (!result) begin
        pos_q <= pos_inc[POSITION_BITS-1:0];
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && result) begin
      found_q <= res_found;
      index_q <= res_index;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_index_o = index_q;

  // ---------------- checks ----------------
  // a miss always carries index zero
  a_miss_index_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_index_o == '0)
    else $error("not-found result with nonzero index");

  // a result closes the search
  a_result_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && result |=> done_q && out_valid_q)
    else $error("search still open after a result");

  // bytes after a result and before a start leave the search closed and give nothing
  a_closed_stays : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && done_q && !string_start_i |-> !result && !shift)
    else $error("closed search produced activity");

  // the position counter never wraps while a search stays open
  a_pos_no_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && active && !result |=> pos_q != '0)
    else $error("position counter wrapped");

endmodule

`default_nettype wire
